// ===== hdl/sitrt_pkg.sv =====
// shared constants, types and tables for the signed integer to radix text block
// no dependencies; every other file refers to it by scoped names
package sitrt_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int MAX_RADIX    = 16;
  localparam int SYMBOL_SLOTS = 16;
  localparam int RADIX_W      = 5;
  localparam int DIGIT_W      = $clog2(SYMBOL_SLOTS);
  localparam int CNT_W        = $clog2(VALUE_BITS + 1);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0]    RADIX_RESET    = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYM_LOW_RESET  = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] SYM_HIGH_RESET = 64'h6665646362613938;

  // floor(2^VALUE_BITS / r), used to estimate the quotient by a multiply
  localparam logic [63:0] POW_VB = 64'd1 << VALUE_BITS;
  localparam logic [VALUE_BITS-1:0] RECIP_TABLE [SYMBOL_SLOTS+1] = '{
    '0, '0,
    VALUE_BITS'(POW_VB / 64'd2),  VALUE_BITS'(POW_VB / 64'd3),
    VALUE_BITS'(POW_VB / 64'd4),  VALUE_BITS'(POW_VB / 64'd5),
    VALUE_BITS'(POW_VB / 64'd6),  VALUE_BITS'(POW_VB / 64'd7),
    VALUE_BITS'(POW_VB / 64'd8),  VALUE_BITS'(POW_VB / 64'd9),
    VALUE_BITS'(POW_VB / 64'd10), VALUE_BITS'(POW_VB / 64'd11),
    VALUE_BITS'(POW_VB / 64'd12), VALUE_BITS'(POW_VB / 64'd13),
    VALUE_BITS'(POW_VB / 64'd14), VALUE_BITS'(POW_VB / 64'd15),
    VALUE_BITS'(POW_VB / 64'd16)
  };

  typedef struct packed {
    logic [RADIX_W-1:0]               radix;
    logic [SYMBOL_SLOTS-1:0][7:0]     symbols;
  } cfg_t;

  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MUL,
    ST_DIV_FIX,
    ST_EMIT_SIGN,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/signed_integer_to_radix_text.sv =====
// Signed integer to radix text, top level: configuration registers and the
// front, queue and back instances; depends on sitrt_pkg and the sitrt_* modules
//
// Usage: in_value enters on in_valid/in_stall; characters leave on
// out_valid/out_stall, each with out_last set on the final character of a value.
// Configuration writes (cfg_index 0 radix, 1 symbols 0..7, 2 symbols 8..15) go in
// on cfg_valid/cfg_ready, ready is always high, and belong between items only.
// The front registers a value, checks the base and hands sign and magnitude to a
// two-entry queue; a value under an invalid base yields no characters at all.
// The back extracts each digit by a reciprocal multiply and then a correction, and
// sends one character per cycle from a registered output while out_stall is low.
// While the queue has room the front keeps accepting values during conversion.
// A stalled output holds its character and the back waits; the queue then fills
// and in_stall rises. Reset clears the queue and control state and loads radix 10
// with symbols "0123456789abcdef".
module signed_integer_to_radix_text (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [sitrt_pkg::VALUE_BITS-1:0]  in_value,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [7:0]                               out_character,
  output logic                                     out_last,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [sitrt_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sitrt_pkg::CFG_DATA_W-1:0]         cfg_data
);

  logic [sitrt_pkg::RADIX_W-1:0]    radix_r;
  logic [sitrt_pkg::CFG_DATA_W-1:0] sym_low_r, sym_high_r;
  sitrt_pkg::cfg_t                  cfg;
  sitrt_pkg::item_t                 push_item, pop_item;
  logic                             q_push, q_pop, q_full, q_empty;

  assign cfg_ready   = 1'b1;
  assign cfg.radix   = radix_r;
  assign cfg.symbols = {sym_high_r, sym_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= sitrt_pkg::RADIX_RESET;
      sym_low_r  <= sitrt_pkg::SYM_LOW_RESET;
      sym_high_r <= sitrt_pkg::SYM_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sitrt_pkg::CFG_RADIX:    radix_r    <= cfg_data[sitrt_pkg::RADIX_W-1:0];
        sitrt_pkg::CFG_SYM_LOW:  sym_low_r  <= cfg_data;
        sitrt_pkg::CFG_SYM_HIGH: sym_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sitrt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  sitrt_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (push_item),
    .pop     (q_pop),
    .rd_item (pop_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  sitrt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

// ===== hdl/sitrt_front.sv =====
// front end: takes input values, checks the configured base, forms sign and magnitude
// depends on sitrt_pkg; feeds sitrt_fifo
module sitrt_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sitrt_pkg::cfg_t                     cfg,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sitrt_pkg::VALUE_BITS-1:0] in_value,
  input  logic                                q_full,
  output logic                                q_push,
  output sitrt_pkg::item_t                    q_item
);

  logic                             st_valid_r, st_valid_nxt;
  logic [sitrt_pkg::VALUE_BITS-1:0] st_value_r;
  logic                             base_ok_r, base_ok_nxt;
  logic                             in_fire;

  // base is bad on a radix outside 2..16, a forbidden symbol or two equal symbols among the first radix
  always_comb begin
    logic bad;
    bad = (cfg.radix < 5'd2) || (cfg.radix > sitrt_pkg::RADIX_W'(sitrt_pkg::MAX_RADIX));
    for (int i = 0; i < sitrt_pkg::SYMBOL_SLOTS; i++) begin
      if (sitrt_pkg::RADIX_W'(i) < cfg.radix) begin
        if (cfg.symbols[i] == 8'h00 || cfg.symbols[i] == sitrt_pkg::CHAR_PLUS ||
            cfg.symbols[i] == sitrt_pkg::CHAR_MINUS) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < sitrt_pkg::SYMBOL_SLOTS; j++) begin
          if (sitrt_pkg::RADIX_W'(j) < cfg.radix && cfg.symbols[j] == cfg.symbols[i]) begin
            bad = 1'b1;
          end
        end
      end
    end
    base_ok_nxt = !bad;
  end

  assign in_stall = st_valid_r && q_full;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (in_fire) begin
      st_valid_nxt = 1'b1;
    end else if (st_valid_r && !q_full) begin
      st_valid_nxt = 1'b0;
    end
  end

  // items under an invalid base are dropped here
  assign q_push     = st_valid_r && !q_full && base_ok_r;
  assign q_item.neg = st_value_r[sitrt_pkg::VALUE_BITS-1];
  assign q_item.mag = st_value_r[sitrt_pkg::VALUE_BITS-1] ? (~st_value_r + 1'b1) : st_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
      base_ok_r  <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
      base_ok_r  <= base_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      st_value_r <= in_value;
    end
  end

endmodule

// ===== hdl/sitrt_fifo.sv =====
// two-entry queue of sign and magnitude items between front and back
// depends on sitrt_pkg
module sitrt_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sitrt_pkg::item_t wr_item,
  input  logic             pop,
  output sitrt_pkg::item_t rd_item,
  output logic             full,
  output logic             empty
);

  sitrt_pkg::item_t mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    case ({push && !full, pop && !empty})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== hdl/sitrt_back.sv =====
// back end: digit extraction by reciprocal multiply and correction, digit stack,
// and the registered character output; depends on sitrt_pkg
module sitrt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sitrt_pkg::cfg_t      cfg,
  input  logic                 q_empty,
  input  sitrt_pkg::item_t     q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_character,
  output logic                 out_last
);

  localparam int VB = sitrt_pkg::VALUE_BITS;

  sitrt_pkg::state_t             state_r, state_nxt;
  logic [sitrt_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          neg_r;
  logic [VB-1:0]                 mag_r;
  logic [2*VB-1:0]               prod_r;
  logic [sitrt_pkg::DIGIT_W-1:0] stk_r [VB];
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_character_r, out_character_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          slot_free;
  logic                          push, pop, load_item, load_prod, load_quot;
  logic [VB-1:0]                 q_est, q_new;
  logic [5:0]                    radix6, qr_lo, rem6, rem_fix;
  logic                          fix;
  logic [sitrt_pkg::DIGIT_W-1:0] digit;

  // estimate is exact or one low; the true remainder is below 2*radix, so 6 bits do
  assign q_est   = prod_r[2*VB-1:VB];
  assign radix6  = {1'b0, cfg.radix};
  assign qr_lo   = q_est[5:0] * radix6;
  assign rem6    = mag_r[5:0] - qr_lo;
  assign fix     = (rem6 >= radix6);
  assign rem_fix = rem6 - radix6;
  assign digit   = fix ? rem_fix[sitrt_pkg::DIGIT_W-1:0] : rem6[sitrt_pkg::DIGIT_W-1:0];
  assign q_new   = q_est + VB'(fix);

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;
    q_pop             = 1'b0;
    push              = 1'b0;
    pop               = 1'b0;
    load_item         = 1'b0;
    load_prod         = 1'b0;
    load_quot         = 1'b0;
    unique case (state_r)
      sitrt_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          load_item = 1'b1;
          cnt_nxt   = '0;
          state_nxt = sitrt_pkg::ST_DIV_MUL;
        end
      end
      sitrt_pkg::ST_DIV_MUL: begin
        load_prod = 1'b1;
        state_nxt = sitrt_pkg::ST_DIV_FIX;
      end
      sitrt_pkg::ST_DIV_FIX: begin
        push      = 1'b1;
        load_quot = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (q_new != '0) begin
          state_nxt = sitrt_pkg::ST_DIV_MUL;
        end else if (neg_r) begin
          state_nxt = sitrt_pkg::ST_EMIT_SIGN;
        end else begin
          state_nxt = sitrt_pkg::ST_EMIT;
        end
      end
      sitrt_pkg::ST_EMIT_SIGN: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = sitrt_pkg::CHAR_MINUS;
          out_last_nxt      = 1'b0;
          state_nxt         = sitrt_pkg::ST_EMIT;
        end
      end
      sitrt_pkg::ST_EMIT: begin
        if (slot_free) begin
          pop               = 1'b1;
          out_valid_nxt     = 1'b1;
          out_character_nxt = cfg.symbols[stk_r[0]];
          out_last_nxt      = (cnt_r == sitrt_pkg::CNT_W'(1));
          cnt_nxt           = cnt_r - 1'b1;
          if (cnt_r == sitrt_pkg::CNT_W'(1)) begin
            state_nxt = sitrt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sitrt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sitrt_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
    if (load_item) begin
      neg_r <= q_item.neg;
      mag_r <= q_item.mag;
    end else if (load_quot) begin
      mag_r <= q_new;
    end
    if (load_prod) begin
      prod_r <= mag_r * sitrt_pkg::RECIP_TABLE[cfg.radix];
    end
  end

  // digit stack: lowest digit pushed first, popped last
  always_ff @(posedge clk) begin
    if (push) begin
      stk_r[0] <= digit;
      for (int i = 1; i < VB; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < VB - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

  a_digit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sitrt_pkg::ST_DIV_FIX |-> ({2'b00, digit} < radix6))
    else $error("extracted digit not below radix");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sitrt_pkg::CNT_W'(VB))
    else $error("digit stack overflow");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sitrt_pkg::ST_EMIT |-> cnt_r != '0)
    else $error("emitting with empty digit stack");

  a_sign_only_neg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sitrt_pkg::ST_EMIT_SIGN |-> neg_r)
    else $error("minus sign for a non-negative value");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sitrt_pkg::ST_EMIT && slot_free && cnt_r == sitrt_pkg::CNT_W'(1))
      |=> (out_last_r && state_r != sitrt_pkg::ST_EMIT && state_r != sitrt_pkg::ST_EMIT_SIGN))
    else $error("last flag not tied to end of text");

endmodule

// ===== tb/sv/tb_signed_integer_to_radix_text.sv =====
// testbench for signed_integer_to_radix_text: directed and random values under many bases,
// checked character by character against a local text predictor
// depends on sitrt_pkg and the signed_integer_to_radix_text rtl
`timescale 1ns / 1ps

module tb_signed_integer_to_radix_text;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 150;
  localparam int HOLD_CYCLES    = 400;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [sitrt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic                                    clk;
  logic                                    rst_n;
  logic                                    in_valid;
  logic                                    in_stall;
  logic signed [sitrt_pkg::VALUE_BITS-1:0] in_value;
  logic                                    out_valid;
  logic                                    out_stall = 1'b0;
  logic [7:0]                              out_character;
  logic                                    out_last;
  logic                                    cfg_valid;
  logic                                    cfg_ready;
  logic [sitrt_pkg::CFG_IDX_W-1:0]         cfg_index;
  logic [sitrt_pkg::CFG_DATA_W-1:0]        cfg_data;

  sitrt_pkg::cfg_t shadow_base;
  text_char_t      expected_text[$];
  int              fail_count = 0;
  int              quiet_cycles = 0;
  int              sender_idle_pct;
  int              rx_stall_pct;
  bit              rx_hold;

  signed_integer_to_radix_text uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit base_usable();
    int r;
    r = shadow_base.radix;
    if (r < 2 || r > sitrt_pkg::MAX_RADIX) return 1'b0;
    for (int i = 0; i < r; i++) begin
      if (shadow_base.symbols[i] == 8'h00 || shadow_base.symbols[i] == sitrt_pkg::CHAR_PLUS ||
          shadow_base.symbols[i] == sitrt_pkg::CHAR_MINUS) return 1'b0;
      for (int j = i + 1; j < r; j++)
        if (shadow_base.symbols[j] == shadow_base.symbols[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void render_text(input logic signed [sitrt_pkg::VALUE_BITS-1:0] v);
    text_char_t ch;
    text_char_t digits[$];
    int         r;
    longint     mag;
    if (!base_usable()) return;
    r = shadow_base.radix;
    mag = v;
    if (v < 0) mag = -mag;
    do begin
      ch.character = shadow_base.symbols[mag % r];
      ch.last = 1'b0;
      digits.push_front(ch);
      mag = mag / r;
    end while (mag != 0);
    digits[digits.size() - 1].last = 1'b1;
    if (v < 0) begin
      ch.character = sitrt_pkg::CHAR_MINUS;
      ch.last = 1'b0;
      expected_text.push_back(ch);
    end
    foreach (digits[i]) expected_text.push_back(digits[i]);
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_value(input logic signed [sitrt_pkg::VALUE_BITS-1:0] v);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    render_text(v);
  endtask

  task automatic write_reg(input logic [sitrt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sitrt_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sitrt_pkg::CFG_RADIX:    shadow_base.radix = data[sitrt_pkg::RADIX_W-1:0];
      sitrt_pkg::CFG_SYM_LOW:  shadow_base.symbols[7:0] = data;
      sitrt_pkg::CFG_SYM_HIGH: shadow_base.symbols[15:8] = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_base(input logic [sitrt_pkg::CFG_DATA_W-1:0] radix_word,
                          input logic [sitrt_pkg::CFG_DATA_W-1:0] low,
                          input logic [sitrt_pkg::CFG_DATA_W-1:0] high);
    write_reg(sitrt_pkg::CFG_RADIX, radix_word);
    write_reg(sitrt_pkg::CFG_SYM_LOW, low);
    write_reg(sitrt_pkg::CFG_SYM_HIGH, high);
  endtask

  // no config write while characters are in flight or a dropped value may still be inside
  task automatic drain_text();
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) out_stall <= rx_hold || ($urandom_range(99) < rx_stall_pct);

  // ---------------------------------------------------------------- checker and watchdog

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected character %h last %b", out_character, out_last);
      end else begin
        want = expected_text.pop_front();
        if (out_character !== want.character || out_last !== want.last) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch: expected character %h last %b, got character %h last %b",
                     want.character, want.last, out_character, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic signed [sitrt_pkg::VALUE_BITS-1:0] random_value();
    longint p;
    int     r;
    int     k;
    r = (shadow_base.radix >= 2 && shadow_base.radix <= sitrt_pkg::MAX_RADIX) ?
        shadow_base.radix : 10;
    case ($urandom_range(4))
      0, 1: return $urandom;
      2:    return $signed($urandom_range(40)) - 20;
      3: begin
        // a power of the radix or one below it, so digit counts roll over
        p = 1;
        k = $urandom_range(31);
        repeat (k) if (p * r <= 64'sd2147483648) p = p * r;
        p = p - $urandom_range(1);
        return $urandom_range(1) ? -p : p;
      end
      default: return $signed($urandom) >>> $urandom_range(31);
    endcase
  endfunction

  task automatic random_base();
    logic [sitrt_pkg::CFG_DATA_W-1:0]        radix_word;
    logic [sitrt_pkg::SYMBOL_SLOTS-1:0][7:0] syms;
    bit                                      used [256];
    logic [7:0]                              s;
    int                                      r;
    int                                      pick;
    int                                      i;
    r = $urandom_range(2, sitrt_pkg::MAX_RADIX);
    for (i = 0; i < sitrt_pkg::SYMBOL_SLOTS; i++) begin
      if (i < r) begin
        do s = $urandom_range(255);
        while (s == 8'h00 || s == sitrt_pkg::CHAR_PLUS || s == sitrt_pkg::CHAR_MINUS ||
               used[s]);
        used[s] = 1'b1;
      end else begin
        s = $urandom_range(255);
      end
      syms[i] = s;
    end
    radix_word = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 4) begin
      radix_word[sitrt_pkg::RADIX_W-1:0] = $urandom_range(1);
    end else if (pick < 8) begin
      radix_word[sitrt_pkg::RADIX_W-1:0] = $urandom_range(sitrt_pkg::MAX_RADIX + 1, 31);
    end else begin
      radix_word[sitrt_pkg::RADIX_W-1:0] = r;
      if (pick < 11) begin
        syms[$urandom_range(r - 1)] = (pick == 8) ? 8'h00 :
                                      (pick == 9) ? sitrt_pkg::CHAR_PLUS :
                                                    sitrt_pkg::CHAR_MINUS;
      end else if (pick < 14) begin
        i = $urandom_range(r - 1);
        syms[i] = syms[(i + 1 + $urandom_range(r - 2)) % r];
      end
    end
    set_base(radix_word, syms[7:0], syms[15:8]);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_base();
    send_value(0);
    send_value(7);
    send_value(-1);
    send_value(10);
    send_value(-10);
    send_value(32'sh7fff_ffff);
    send_value(32'sh8000_0000);
    send_value(1000000000);
    send_value(-999999999);
  endtask

  task automatic test_extreme_bases();
    drain_text();
    set_base(64'd2, sitrt_pkg::SYM_LOW_RESET, sitrt_pkg::SYM_HIGH_RESET);
    send_value(32'sh7fff_ffff);
    send_value(32'sh8000_0000);
    send_value(0);
    drain_text();
    write_reg(sitrt_pkg::CFG_RADIX, 64'd16);
    send_value(32'shdead_beef);
    send_value(-1);
    drain_text();
    // high-bit and unusual bytes as symbols, in scrambled order
    set_base(64'd16, 64'hf0e1_d2c3_b4a5_9687, 64'h7f6e_5d4c_3b2a_1908);
    send_value(0);
    send_value(32'sh1234_5678);
    drain_text();
    set_base(64'd3, sitrt_pkg::SYM_LOW_RESET, sitrt_pkg::SYM_HIGH_RESET);
    send_value(32'sh8000_0000);
  endtask

  task automatic test_rejected_bases();
    drain_text();
    write_reg(sitrt_pkg::CFG_RADIX, 64'hffff_ffff_ffff_ffff);
    send_value(123);
    drain_text();
    write_reg(sitrt_pkg::CFG_RADIX, 64'ha5a5_a5a5_a5a5_a5a0);
    send_value(-5);
    drain_text();
    write_reg(sitrt_pkg::CFG_RADIX, 64'h0000_0000_0000_0001);
    send_value(1);
    drain_text();
    write_reg(sitrt_pkg::CFG_RADIX, 64'h0000_0000_0000_0011);
    send_value(16);
    drain_text();
    // plus sign sits in slot 4: fatal for radix 5, ignored for radix 4
    set_base(64'd5, 64'h3736_352b_3332_3130, sitrt_pkg::SYM_HIGH_RESET);
    send_value(-7);
    drain_text();
    write_reg(sitrt_pkg::CFG_RADIX, 64'd4);
    send_value(-7);
    drain_text();
    set_base(64'd10, 64'h3736_3534_2d32_3130, sitrt_pkg::SYM_HIGH_RESET);
    send_value(42);
    drain_text();
    write_reg(sitrt_pkg::CFG_SYM_LOW, 64'h3736_3534_3332_3100);
    send_value(0);
    drain_text();
    // slot 15 repeats slot 8: fatal for radix 16, ignored for radix 15
    set_base(64'd16, sitrt_pkg::SYM_LOW_RESET, 64'h3865_6463_6261_3938);
    send_value(255);
    drain_text();
    write_reg(sitrt_pkg::CFG_RADIX, 64'd15);
    send_value(-255);
    drain_text();
    // an unused index must leave every register alone
    set_base(64'd10, sitrt_pkg::SYM_LOW_RESET, sitrt_pkg::SYM_HIGH_RESET);
    write_reg(CFG_UNUSED, 64'hffff_ffff_ffff_ffff);
    send_value(-2147483647);
  endtask

  task automatic test_output_backpressure();
    drain_text();
    set_base(64'd2, sitrt_pkg::SYM_LOW_RESET, sitrt_pkg::SYM_HIGH_RESET);
    sender_idle_pct = 0;
    rx_stall_pct = 0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        repeat (10) send_value($urandom | 32'h8000_0000);
      end
    join
  endtask

  task automatic test_random_traffic();
    int idle_pct [4] = '{0, 82, 0, 22};
    int stall_pct [4] = '{0, 0, 82, 22};
    for (int ph = 0; ph < 4; ph++) begin
      repeat (4) begin
        drain_text();
        sender_idle_pct = idle_pct[ph];
        rx_stall_pct = stall_pct[ph];
        random_base();
        repeat (21) send_value(random_value());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    cfg_valid = 1'b0;
    cfg_index = sitrt_pkg::CFG_RADIX;
    cfg_data = '0;
    sender_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold = 1'b0;
    shadow_base.radix = sitrt_pkg::RADIX_RESET;
    shadow_base.symbols = {sitrt_pkg::SYM_HIGH_RESET, sitrt_pkg::SYM_LOW_RESET};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_base();
    test_extreme_bases();
    test_rejected_bases();
    test_output_backpressure();
    test_random_traffic();
    drain_text();

    if (fail_count == 0 && expected_text.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
